// File: hw/rtl/vmrf_pkg.sv
package vmrf_pkg;

   localparam int NUM_DEV = 3;

   // default window layout
   localparam int BLOCK_BASE_DEF    = 4096;
   localparam int CONSOLE_BASE_DEF  = 8192;
   localparam int GPU_BASE_DEF      = 12288;
   localparam int REGION_BYTES_DEF  = 512;
   localparam int QUEUE_NUM_MAX_DEF = 64;

   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_RAISE = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   // register offsets inside one device region
   localparam logic [15:0] R_MAGIC     = 16'h000;
   localparam logic [15:0] R_VERSION   = 16'h004;
   localparam logic [15:0] R_DEVICE_ID = 16'h008;
   localparam logic [15:0] R_VENDOR_ID = 16'h00C;
   localparam logic [15:0] R_DEV_FEAT  = 16'h010;
   localparam logic [15:0] R_DRV_FEAT  = 16'h020;
   localparam logic [15:0] R_QSEL      = 16'h030;
   localparam logic [15:0] R_QMAX      = 16'h034;
   localparam logic [15:0] R_QNUM      = 16'h038;
   localparam logic [15:0] R_QREADY    = 16'h044;
   localparam logic [15:0] R_NOTIFY    = 16'h050;
   localparam logic [15:0] R_ISTAT     = 16'h060;
   localparam logic [15:0] R_IACK      = 16'h064;
   localparam logic [15:0] R_STATUS    = 16'h070;
   localparam logic [15:0] R_DESC_LO   = 16'h080;
   localparam logic [15:0] R_DESC_HI   = 16'h084;
   localparam logic [15:0] R_DRV_LO    = 16'h090;
   localparam logic [15:0] R_DRV_HI    = 16'h094;
   localparam logic [15:0] R_DEV_LO    = 16'h0A0;
   localparam logic [15:0] R_DEV_HI    = 16'h0A4;

   localparam logic [31:0] MAGIC_VALUE = 32'h7472_6976;
   localparam logic [31:0] VERSION_VAL = 32'd2;
   localparam logic [31:0] VENDOR_VAL  = 32'h0000_1AF4;
   localparam int          ST_DRIVER_OK_BIT = 2;

   // per-device identity: block, console, gpu
   localparam logic [31:0] DEV_IDS   [NUM_DEV] = '{32'd2, 32'd3, 32'd16};
   localparam logic [31:0] DEV_FEATS [NUM_DEV] = '{32'd1, 32'd0, 32'd0};

   // configuration register indexes
   localparam logic CSR_IDX_ENABLED = 1'b0;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] offset;
      logic [31:0] write_data;
      logic [1:0]  event_device;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        notify_valid;
      logic [1:0]  notify_device;
      logic [2:0]  irq_pending;
   } rsp_type;

   // one decoded access toward a device register set
   typedef struct packed {
      logic        rd;
      logic        wr;
      logic        raise;
      logic [15:0] reg_off;
      logic [31:0] data;
   } dev_req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        notify;
      logic        irq;
   } dev_rsp_type;

endpackage

// File: hw/rtl/vmrf_device.sv
module vmrf_device #(
   parameter logic [31:0] DEVICE_ID       = 32'd2,
   parameter logic [31:0] DEVICE_FEATURES = 32'd0,
   parameter int          QUEUE_NUM_MAX   = vmrf_pkg::QUEUE_NUM_MAX_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  vmrf_pkg::dev_req_type  dev_req,
   output vmrf_pkg::dev_rsp_type  dev_rsp
);
   import vmrf_pkg::*;

   localparam logic [31:0] QMAX32 = 32'(QUEUE_NUM_MAX);

   logic [31:0] drv_feat_ff, drv_feat_in;
   logic [31:0] qsel_ff, qsel_in;
   logic [6:0]  qsize_ff, qsize_in;
   logic        qready_ff, qready_in;
   logic [31:0] istat_ff, istat_in;
   logic [31:0] status_ff, status_in;
   logic [63:0] desc_ff, desc_in;
   logic [63:0] drv_ff, drv_in;
   logic [63:0] dev_ff, dev_in;
   logic [31:0] rd_value;

   // state update
   always_comb begin
      drv_feat_in = drv_feat_ff;
      qsel_in     = qsel_ff;
      qsize_in    = qsize_ff;
      qready_in   = qready_ff;
      istat_in    = istat_ff;
      status_in   = status_ff;
      desc_in     = desc_ff;
      drv_in      = drv_ff;
      dev_in      = dev_ff;
      if (dev_req.raise) begin
         istat_in = istat_ff | 32'd1;
      end
      if (dev_req.wr) begin
         case (dev_req.reg_off)
            R_DRV_FEAT: drv_feat_in = dev_req.data;
            R_QSEL:     qsel_in = dev_req.data;
            R_QNUM:     qsize_in = (dev_req.data < QMAX32) ? dev_req.data[6:0] : QMAX32[6:0];
            R_QREADY:   qready_in = dev_req.data[0];
            R_IACK:     istat_in = istat_ff & ~dev_req.data;
            R_STATUS: begin
               status_in = dev_req.data;
               if (dev_req.data == 32'd0) begin
                  qready_in = 1'b0;
                  istat_in  = 32'd0;
               end
            end
            R_DESC_LO:  desc_in = {desc_ff[63:32], dev_req.data};
            R_DESC_HI:  desc_in = {dev_req.data, desc_ff[31:0]};
            R_DRV_LO:   drv_in = {drv_ff[63:32], dev_req.data};
            R_DRV_HI:   drv_in = {dev_req.data, drv_ff[31:0]};
            R_DEV_LO:   dev_in = {dev_ff[63:32], dev_req.data};
            R_DEV_HI:   dev_in = {dev_req.data, dev_ff[31:0]};
            default:    ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (dev_req.reg_off)
         R_MAGIC:     rd_value = MAGIC_VALUE;
         R_VERSION:   rd_value = VERSION_VAL;
         R_DEVICE_ID: rd_value = DEVICE_ID;
         R_VENDOR_ID: rd_value = VENDOR_VAL;
         R_DEV_FEAT:  rd_value = DEVICE_FEATURES;
         R_DRV_FEAT:  rd_value = drv_feat_ff;
         R_QSEL:      rd_value = qsel_ff;
         R_QMAX:      rd_value = QMAX32;
         R_QNUM:      rd_value = {25'd0, qsize_ff};
         R_QREADY:    rd_value = {31'd0, qready_ff};
         R_ISTAT:     rd_value = istat_ff;
         R_STATUS:    rd_value = status_ff;
         R_DESC_LO:   rd_value = desc_ff[31:0];
         R_DESC_HI:   rd_value = desc_ff[63:32];
         R_DRV_LO:    rd_value = drv_ff[31:0];
         R_DRV_HI:    rd_value = drv_ff[63:32];
         R_DEV_LO:    rd_value = dev_ff[31:0];
         R_DEV_HI:    rd_value = dev_ff[63:32];
         default:     rd_value = 32'd0;
      endcase
   end

   always_comb begin
      dev_rsp.read_data = dev_req.rd ? rd_value : 32'd0;
      dev_rsp.notify    = dev_req.wr && (dev_req.reg_off == R_NOTIFY)
                          && status_ff[ST_DRIVER_OK_BIT];
      dev_rsp.irq       = (istat_in != 32'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drv_feat_ff <= '0;
         qsel_ff     <= '0;
         qsize_ff    <= '0;
         qready_ff   <= 1'b0;
         istat_ff    <= '0;
         status_ff   <= '0;
         desc_ff     <= '0;
         drv_ff      <= '0;
         dev_ff      <= '0;
      end else begin
         drv_feat_ff <= drv_feat_in;
         qsel_ff     <= qsel_in;
         qsize_ff    <= qsize_in;
         qready_ff   <= qready_in;
         istat_ff    <= istat_in;
         status_ff   <= status_in;
         desc_ff     <= desc_in;
         drv_ff      <= drv_in;
         dev_ff      <= dev_in;
      end
   end

endmodule

// File: hw/rtl/virtio_mmio_register_file_unit.sv
// virtio mmio (version 2) register file for three devices: block, console and gpu.
// each request is a read, a write or a device-side interrupt raise; every request
// gives exactly one response carrying read data, a queue notify pulse and the
// per-device pending interrupt bits as they stand after the request. a request
// is taken into an input register, then decoded and applied to the device
// registers on its way into the response register, so one request per clock is
// sustained while responses are not stalled; an empty input register takes a new
// request while the previous response is still stalled. regions start at
// BLOCK_BASE, CONSOLE_BASE and GPU_BASE and span REGION_BYTES each, overlaps go
// to the first device in that order. the csr port holds one register, enabled
// (reset 1): when cleared, reads return zero and writes are dropped, interrupt
// raises still land. csr writes are only expected while no request is in flight.
module virtio_mmio_register_file_unit #(
   parameter int BLOCK_BASE    = vmrf_pkg::BLOCK_BASE_DEF,
   parameter int CONSOLE_BASE  = vmrf_pkg::CONSOLE_BASE_DEF,
   parameter int GPU_BASE      = vmrf_pkg::GPU_BASE_DEF,
   parameter int REGION_BYTES  = vmrf_pkg::REGION_BYTES_DEF,
   parameter int QUEUE_NUM_MAX = vmrf_pkg::QUEUE_NUM_MAX_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  vmrf_pkg::req_type req_payload,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output vmrf_pkg::rsp_type rsp_payload,
   // configuration port
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import vmrf_pkg::*;

   localparam logic [16:0] BASES [NUM_DEV] = '{17'(BLOCK_BASE), 17'(CONSOLE_BASE),
                                               17'(GPU_BASE)};
   localparam logic [16:0] SPAN = 17'(REGION_BYTES);

   // pipeline registers
   logic        req_valid_ff, req_valid_in;
   req_type     req_ff, req_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic        enabled_ff, enabled_in;

   logic        out_ready;   // response register can take a new value
   logic        advance;     // request in the input register is applied this cycle
   logic [NUM_DEV-1:0] hit, sel;
   dev_req_type dev_req [NUM_DEV];
   dev_rsp_type dev_rsp [NUM_DEV];

   // handshake: input register refills whenever it is empty or its content moves on
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign advance   = req_valid_ff && out_ready;
   assign req_stall = req_valid_ff && !out_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      req_valid_in = req_valid_ff;
      req_in       = req_ff;
      if (!req_stall) begin
         req_valid_in = req_valid;
         req_in       = req_payload;
      end
   end

   // region decode, first match wins
   always_comb begin
      for (int d = 0; d < NUM_DEV; d++) begin
         hit[d] = ({1'b0, req_ff.offset} >= BASES[d])
                  && ({1'b0, req_ff.offset} < BASES[d] + SPAN);
      end
      sel[0] = hit[0];
      sel[1] = hit[1] && !hit[0];
      sel[2] = hit[2] && !hit[1] && !hit[0];
   end

   // per-device access, gated with the transfer out of the input register
   always_comb begin
      for (int d = 0; d < NUM_DEV; d++) begin
         dev_req[d].rd      = advance && enabled_ff && sel[d]
                              && (cmd_type'(req_ff.command) == CMD_READ);
         dev_req[d].wr      = advance && enabled_ff && sel[d]
                              && (cmd_type'(req_ff.command) == CMD_WRITE);
         dev_req[d].raise   = advance && (cmd_type'(req_ff.command) == CMD_RAISE)
                              && (req_ff.event_device == 2'(d));
         dev_req[d].reg_off = req_ff.offset - BASES[d][15:0];
         dev_req[d].data    = req_ff.write_data;
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < NUM_DEV; gi++) begin : g_dev
         vmrf_device #(
            .DEVICE_ID       (DEV_IDS[gi]),
            .DEVICE_FEATURES (DEV_FEATS[gi]),
            .QUEUE_NUM_MAX   (QUEUE_NUM_MAX)
         ) u_dev (
            .clock   (clock),
            .reset   (reset),
            .dev_req (dev_req[gi]),
            .dev_rsp (dev_rsp[gi])
         );
      end
   endgenerate

   // merge device answers; at most one device reads or notifies
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_ready) begin
         rsp_valid_in = req_valid_ff;
      end
      if (advance) begin
         rsp_in.read_data     = '0;
         rsp_in.notify_valid  = 1'b0;
         rsp_in.notify_device = '0;
         for (int d = 0; d < NUM_DEV; d++) begin
            rsp_in.read_data    = rsp_in.read_data | dev_rsp[d].read_data;
            rsp_in.notify_valid = rsp_in.notify_valid | dev_rsp[d].notify;
            if (dev_rsp[d].notify) begin
               rsp_in.notify_device = 2'(d);
            end
            rsp_in.irq_pending[d] = dev_rsp[d].irq;
         end
      end
   end

   // csr: one register, enabled, at byte address 0
   assign csr_pready = 1'b1;

   always_comb begin
      enabled_in = enabled_ff;
      if (csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == CSR_IDX_ENABLED)) begin
         enabled_in = csr_pwdata[0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_IDX_ENABLED) ? {31'd0, enabled_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         enabled_ff   <= 1'b1;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         enabled_ff   <= enabled_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

endmodule

// File: hw/rtl/vmrf_checker.sv
module vmrf_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input vmrf_pkg::rsp_type rsp_payload
);
   import vmrf_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // requests are only held back by a stalled response
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && rsp_stall) |-> !req_stall)
      else $error("request stalled while response side free");

   // notify device is only reported with a notify, and never out of range
   a_notify_dev: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.notify_valid ? (rsp_payload.notify_device != 2'd3)
                                              : (rsp_payload.notify_device == 2'd0)))
      else $error("bad notify device");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind virtio_mmio_register_file_unit vmrf_checker u_vmrf_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

// File: tb/sv/virtio_mmio_register_file_unit_test.sv
module virtio_mmio_register_file_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import vmrf_pkg::*;

   // run length guard and the settle time after the last response
   localparam int CYCLE_LIMIT  = 300000;
   localparam int SETTLE_CYCLES = 8;

   // region bases of the three devices at their default layout
   localparam logic [15:0] BLK = 16'(BLOCK_BASE_DEF);
   localparam logic [15:0] CON = 16'(CONSOLE_BASE_DEF);
   localparam logic [15:0] GPU = 16'(GPU_BASE_DEF);

   // one request waiting to go out, with an optional typed-in response
   typedef struct packed {
      req_type    req;
      logic       fixed;
      rsp_type    rsp;
   } offered_type;

   localparam logic FIXED   = 1'b1;
   localparam logic PREDICT = 1'b0;
   localparam rsp_type NO_RSP = '0;

   // directed stimulus: fixed rows carry values readable at a glance,
   // the others go through the register model
   localparam offered_type DIRECTED_ROWS [27] = '{
      // identification registers straight after reset
      '{'{CMD_READ,  BLK + R_MAGIC,     32'h0,         2'd0}, FIXED,
        '{MAGIC_VALUE, 1'b0, 2'd0, 3'b000}},
      '{'{CMD_READ,  CON + R_VERSION,   32'h0,         2'd0}, FIXED,
        '{VERSION_VAL, 1'b0, 2'd0, 3'b000}},
      '{'{CMD_READ,  GPU + R_DEVICE_ID, 32'h0,         2'd0}, FIXED,
        '{32'd16, 1'b0, 2'd0, 3'b000}},
      '{'{CMD_READ,  BLK + R_DEVICE_ID, 32'h0,         2'd0}, FIXED,
        '{32'd2, 1'b0, 2'd0, 3'b000}},
      '{'{CMD_READ,  CON + R_DEVICE_ID, 32'h0,         2'd0}, FIXED,
        '{32'd3, 1'b0, 2'd0, 3'b000}},
      '{'{CMD_READ,  GPU + R_VENDOR_ID, 32'h0,         2'd0}, FIXED,
        '{VENDOR_VAL, 1'b0, 2'd0, 3'b000}},
      '{'{CMD_READ,  BLK + R_DEV_FEAT,  32'h0,         2'd0}, FIXED,
        '{32'd1, 1'b0, 2'd0, 3'b000}},
      '{'{CMD_READ,  BLK + R_QMAX,      32'h0,         2'd0}, FIXED,
        '{32'(QUEUE_NUM_MAX_DEF), 1'b0, 2'd0, 3'b000}},
      // unaligned, unmapped and just past the block region
      '{'{CMD_READ,  BLK + 16'h0001,    32'hFFFF_FFFF, 2'd3}, FIXED, NO_RSP},
      '{'{CMD_READ,  16'hFFFF,          32'h0,         2'd0}, FIXED, NO_RSP},
      '{'{CMD_READ,  BLK + 16'h0200,    32'h0,         2'd0}, FIXED, NO_RSP},
      // queue size above the maximum gets clamped
      '{'{CMD_WRITE, BLK + R_QNUM,      32'hFFFF_FFFF, 2'd3}, FIXED, NO_RSP},
      '{'{CMD_READ,  BLK + R_QNUM,      32'h0,         2'd0}, PREDICT, NO_RSP},
      // queue ready keeps bit 0 only
      '{'{CMD_WRITE, CON + R_QREADY,    32'hFFFF_FFFF, 2'd0}, PREDICT, NO_RSP},
      '{'{CMD_READ,  CON + R_QREADY,    32'h0,         2'd0}, PREDICT, NO_RSP},
      // interrupt raises, including the ignored fourth device and a no-op
      '{'{CMD_RAISE, 16'hFFFF,          32'hFFFF_FFFF, 2'd0}, PREDICT, NO_RSP},
      '{'{CMD_RAISE, 16'h0000,          32'h0,         2'd2}, PREDICT, NO_RSP},
      '{'{CMD_RAISE, 16'h0000,          32'h0,         2'd3}, PREDICT, NO_RSP},
      '{'{CMD_NOP,   BLK + R_STATUS,    32'h0,         2'd1}, PREDICT, NO_RSP},
      // ack clears the written bits
      '{'{CMD_WRITE, GPU + R_IACK,      32'h0000_0001, 2'd0}, PREDICT, NO_RSP},
      // notify without and then with driver-ok
      '{'{CMD_WRITE, BLK + R_NOTIFY,    32'h0,         2'd0}, PREDICT, NO_RSP},
      '{'{CMD_WRITE, BLK + R_STATUS,    32'h0000_000F, 2'd0}, PREDICT, NO_RSP},
      '{'{CMD_WRITE, BLK + R_NOTIFY,    32'h0,         2'd0}, PREDICT, NO_RSP},
      // ring address halves merge separately
      '{'{CMD_WRITE, BLK + R_DESC_HI,   32'hFFFF_FFFF, 2'd0}, PREDICT, NO_RSP},
      '{'{CMD_READ,  BLK + R_DESC_HI,   32'h0,         2'd0}, PREDICT, NO_RSP},
      // status of zero also drops ready and interrupts
      '{'{CMD_WRITE, BLK + R_STATUS,    32'h0,         2'd0}, PREDICT, NO_RSP},
      '{'{CMD_READ,  BLK + R_ISTAT,     32'h0,         2'd0}, PREDICT, NO_RSP}
   };

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // register model state, one entry per device
   logic        shadow_enabled;
   logic [31:0] shadow_drv_feat [NUM_DEV];
   logic [31:0] shadow_qsel     [NUM_DEV];
   logic [6:0]  shadow_qsize    [NUM_DEV];
   logic        shadow_qready   [NUM_DEV];
   logic [31:0] shadow_istat    [NUM_DEV];
   logic [31:0] shadow_status   [NUM_DEV];
   logic [63:0] shadow_desc     [NUM_DEV];
   logic [63:0] shadow_drv_area [NUM_DEV];
   logic [63:0] shadow_dev_area [NUM_DEV];

   offered_type outgoing_q [$];        // requests not yet transferred
   rsp_type     pending_responses [$]; // predicted responses, oldest first
   logic        offer_live = 1'b0;     // a request is on the channel
   int          sender_idle_pct   = 0;
   int          receiver_idle_pct = 0;
   int          rsp_hold_cycles   = 0;
   int          mismatches        = 0;
   int          responses_seen    = 0;
   int          cycle_count       = 0;

   virtio_mmio_register_file_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // map a window offset to a device and its register offset, first match wins
   function automatic int decode_window(input logic [15:0] off, output logic [15:0] roff);
      int bases [NUM_DEV];
      bases = '{BLOCK_BASE_DEF, CONSOLE_BASE_DEF, GPU_BASE_DEF};
      roff = '0;
      for (int d = 0; d < NUM_DEV; d++) begin
         if (int'(off) >= bases[d] && int'(off) < bases[d] + REGION_BYTES_DEF) begin
            roff = 16'(int'(off) - bases[d]);
            return d;
         end
      end
      return -1;
   endfunction

   // apply one request to the register model and return the response it gives
   function automatic rsp_type model_register_access(input req_type rq);
      rsp_type     res;
      logic [15:0] roff;
      logic [31:0] v;
      int          dev;
      res = '0;
      v = rq.write_data;
      if (rq.command == CMD_RAISE) begin
         // raises land even while disabled, device 3 is dropped
         if (rq.event_device < NUM_DEV) shadow_istat[rq.event_device] |= 32'd1;
      end else if ((rq.command == CMD_READ || rq.command == CMD_WRITE) && shadow_enabled) begin
         dev = decode_window(rq.offset, roff);
         if (dev >= 0 && rq.command == CMD_READ) begin
            case (roff)
               R_MAGIC:     res.read_data = MAGIC_VALUE;
               R_VERSION:   res.read_data = VERSION_VAL;
               R_DEVICE_ID: res.read_data = DEV_IDS[dev];
               R_VENDOR_ID: res.read_data = VENDOR_VAL;
               R_DEV_FEAT:  res.read_data = DEV_FEATS[dev];
               R_DRV_FEAT:  res.read_data = shadow_drv_feat[dev];
               R_QSEL:      res.read_data = shadow_qsel[dev];
               R_QMAX:      res.read_data = 32'(QUEUE_NUM_MAX_DEF);
               R_QNUM:      res.read_data = 32'(shadow_qsize[dev]);
               R_QREADY:    res.read_data = 32'(shadow_qready[dev]);
               R_ISTAT:     res.read_data = shadow_istat[dev];
               R_STATUS:    res.read_data = shadow_status[dev];
               R_DESC_LO:   res.read_data = shadow_desc[dev][31:0];
               R_DESC_HI:   res.read_data = shadow_desc[dev][63:32];
               R_DRV_LO:    res.read_data = shadow_drv_area[dev][31:0];
               R_DRV_HI:    res.read_data = shadow_drv_area[dev][63:32];
               R_DEV_LO:    res.read_data = shadow_dev_area[dev][31:0];
               R_DEV_HI:    res.read_data = shadow_dev_area[dev][63:32];
               default:     res.read_data = '0;
            endcase
         end else if (dev >= 0) begin
            case (roff)
               R_DRV_FEAT: shadow_drv_feat[dev] = v;
               R_QSEL:     shadow_qsel[dev] = v;
               R_QNUM: begin
                  shadow_qsize[dev] = (v < QUEUE_NUM_MAX_DEF) ? v[6:0] : 7'(QUEUE_NUM_MAX_DEF);
               end
               R_QREADY:   shadow_qready[dev] = v[0];
               R_IACK:     shadow_istat[dev] &= ~v;
               R_STATUS: begin
                  shadow_status[dev] = v;
                  if (v == 32'd0) begin
                     shadow_qready[dev] = 1'b0;
                     shadow_istat[dev] = '0;
                  end
               end
               R_NOTIFY: begin
                  if (shadow_status[dev][ST_DRIVER_OK_BIT]) begin
                     res.notify_valid = 1'b1;
                     res.notify_device = 2'(dev);
                  end
               end
               R_DESC_LO:  shadow_desc[dev][31:0] = v;
               R_DESC_HI:  shadow_desc[dev][63:32] = v;
               R_DRV_LO:   shadow_drv_area[dev][31:0] = v;
               R_DRV_HI:   shadow_drv_area[dev][63:32] = v;
               R_DEV_LO:   shadow_dev_area[dev][31:0] = v;
               R_DEV_HI:   shadow_dev_area[dev][63:32] = v;
               default: ;
            endcase
         end
      end
      for (int d = 0; d < NUM_DEV; d++) res.irq_pending[d] = (shadow_istat[d] != 32'd0);
      return res;
   endfunction

   // mostly well-formed accesses to known registers, the rest is noise
   function automatic req_type draw_access();
      req_type     r;
      logic [15:0] roff;
      logic [15:0] known [20] = '{R_MAGIC, R_VERSION, R_DEVICE_ID, R_VENDOR_ID, R_DEV_FEAT,
                                  R_DRV_FEAT, R_QSEL, R_QMAX, R_QNUM, R_QREADY, R_NOTIFY,
                                  R_ISTAT, R_IACK, R_STATUS, R_DESC_LO, R_DESC_HI,
                                  R_DRV_LO, R_DRV_HI, R_DEV_LO, R_DEV_HI};
      logic [15:0] bases [NUM_DEV] = '{BLK, CON, GPU};
      int          pick;
      pick = $urandom_range(0, 99);
      r.write_data = $urandom;
      r.event_device = 2'($urandom_range(0, 3));
      roff = known[$urandom_range(0, 19)];
      r.offset = bases[$urandom_range(0, NUM_DEV - 1)] + roff;
      if (pick < 40) begin
         r.command = CMD_READ;
      end else if (pick < 75) begin
         r.command = CMD_WRITE;
         // bias the data toward values that change behavior
         case (roff)
            R_STATUS: begin
               case ($urandom_range(0, 3))
                  0: r.write_data = '0;
                  1: r.write_data = 32'h0000_000F;
                  2: r.write_data = 32'(1 << ST_DRIVER_OK_BIT) | 32'($urandom_range(0, 255));
                  default: ;
               endcase
            end
            R_QNUM: if ($urandom_range(0, 1) == 1) r.write_data = 32'($urandom_range(0, 80));
            R_IACK: if ($urandom_range(0, 1) == 1) r.write_data = 32'($urandom_range(0, 3));
            default: ;
         endcase
      end else if (pick < 88) begin
         r.command = CMD_RAISE;
      end else begin
         // any command, unaligned or unmapped offsets
         r.command = 2'($urandom_range(0, 3));
         if ($urandom_range(0, 1) == 1) r.offset = 16'($urandom);
         else r.offset = bases[$urandom_range(0, NUM_DEV - 1)] +
                         16'($urandom_range(0, REGION_BYTES_DEF - 1));
      end
      return r;
   endfunction

   task automatic queue_random(input int count);
      offered_type item;
      for (int i = 0; i < count; i++) begin
         item.req = draw_access();
         item.fixed = PREDICT;
         item.rsp = NO_RSP;
         outgoing_q.push_back(item);
      end
   endtask

   // wait until every request went out and every response came back
   task automatic wait_drained();
      while (outgoing_q.size() != 0 || pending_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // apb-style access: setup cycle, then access cycle until pready
   task automatic csr_access(input logic write, input logic [2:0] addr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // program the enable register while idle and read it back
   task automatic program_enabled(input logic value);
      logic [31:0] readback;
      wait_drained();
      csr_access(1'b1, 3'(CSR_IDX_ENABLED) << 2, {31'd0, value}, readback);
      shadow_enabled = value;
      csr_access(1'b0, 3'(CSR_IDX_ENABLED) << 2, '0, readback);
      if (readback !== {31'd0, value}) begin
         mismatches++;
         if (mismatches <= 10)
            $display("enable readback mismatch: expected %h got %h", {31'd0, value}, readback);
      end
   endtask

   // request side: offer the next transfer at the falling edge, hold it while stalled
   always @(negedge clock) begin
      if (!offer_live) begin
         if (!reset && outgoing_q.size() != 0 &&
             $urandom_range(0, 99) >= sender_idle_pct) begin
            req_payload <= outgoing_q[0].req;
            req_valid   <= 1'b1;
            offer_live  = 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response side: random stall, or a long hold-off when asked
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_cycles--;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
      end
   end

   // both channels are sampled at the rising edge
   always @(posedge clock) begin : watch_transfers
      rsp_type want;
      if (!reset) begin
         // request transfer: run the model, or take the typed-in response
         if (req_valid && !req_stall) begin
            want = model_register_access(req_payload);
            if (outgoing_q[0].fixed) want = outgoing_q[0].rsp;
            pending_responses.push_back(want);
            void'(outgoing_q.pop_front());
            offer_live = 1'b0;
         end
         // response transfer: compare against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            responses_seen++;
            if (pending_responses.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response %0d arrived with none expected: rd=%h nv=%b nd=%0d irq=%b",
                           responses_seen, rsp_payload.read_data, rsp_payload.notify_valid,
                           rsp_payload.notify_device, rsp_payload.irq_pending);
            end else begin
               want = pending_responses.pop_front();
               if (rsp_payload.read_data !== want.read_data ||
                   rsp_payload.notify_valid !== want.notify_valid ||
                   rsp_payload.notify_device !== want.notify_device ||
                   rsp_payload.irq_pending !== want.irq_pending) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("response %0d mismatch: expected rd=%h nv=%b nd=%0d irq=%b, %s",
                              responses_seen, want.read_data, want.notify_valid,
                              want.notify_device, want.irq_pending,
                              $sformatf("got rd=%h nv=%b nd=%0d irq=%b",
                                        rsp_payload.read_data, rsp_payload.notify_valid,
                                        rsp_payload.notify_device, rsp_payload.irq_pending));
               end
            end
         end
      end
   end

   // cycle counter that ends a hung run
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin : run_sequence
      // model reset state
      shadow_enabled = 1'b1;
      for (int d = 0; d < NUM_DEV; d++) begin
         shadow_drv_feat[d] = '0;
         shadow_qsel[d]     = '0;
         shadow_qsize[d]    = '0;
         shadow_qready[d]   = 1'b0;
         shadow_istat[d]    = '0;
         shadow_status[d]   = '0;
         shadow_desc[d]     = '0;
         shadow_drv_area[d] = '0;
         shadow_dev_area[d] = '0;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table, sender idles lightly, receiver heavily
      sender_idle_pct   = 28;
      receiver_idle_pct = 81;
      program_enabled(1'b1);
      foreach (DIRECTED_ROWS[i]) outgoing_q.push_back(DIRECTED_ROWS[i]);
      wait_drained();

      // random traffic while the receiver holds off long enough to back up the block
      rsp_hold_cycles = 400;
      queue_random(330);
      wait_drained();

      // disabled: reads give zero, writes drop, raises still land
      sender_idle_pct   = 81;
      receiver_idle_pct = 28;
      program_enabled(1'b0);
      queue_random(150);
      wait_drained();

      // back to enabled at full rate, with a drain in the middle
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      program_enabled(1'b1);
      queue_random(250);
      wait_drained();
      queue_random(250);
      wait_drained();

      if (mismatches == 0 && pending_responses.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/vmrf_pkg.sv
hw/rtl/vmrf_device.sv
hw/rtl/virtio_mmio_register_file_unit.sv
hw/rtl/vmrf_checker.sv
tb/sv/virtio_mmio_register_file_unit_test.sv
